>>> design/acs_pkg.sv
package acs_pkg;

  // Width of every result tally field and of both threshold registers.
  localparam int unsigned FIELD_W = 24;
  localparam int unsigned NUM_TALLIES = 11;
  localparam int unsigned COUNT_BITS_DEF = 24;

  // Tally slots, in result order.
  localparam int unsigned T_COLS = 0;
  localparam int unsigned T_GAPA = 1;
  localparam int unsigned T_GAPB = 2;
  localparam int unsigned T_ALIGNED = 3;
  localparam int unsigned T_MATCH = 4;
  localparam int unsigned T_MISMATCH = 5;
  localparam int unsigned T_TRANSITION = 6;
  localparam int unsigned T_TRANSVERSION = 7;
  localparam int unsigned T_UPA = 8;
  localparam int unsigned T_UPB = 9;
  localparam int unsigned T_UPMATCH = 10;

  localparam logic [FIELD_W-1:0] MIN_COLUMNS_RST = 24'd900;
  localparam logic [FIELD_W-1:0] MIN_UPPER_RST = 24'd100;

  // ASCII codes used by the column classifier.
  localparam logic [7:0] CH_GAP = 8'h2D;
  localparam logic [7:0] CH_N = 8'h4E;
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CH_UC_FIRST = 8'h41;
  localparam logic [7:0] CH_UC_LAST = 8'h5A;
  localparam logic [7:0] CH_LC_FIRST = 8'h61;
  localparam logic [7:0] CH_LC_LAST = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_COLUMNS = 2'd0,
    CFG_MIN_UPPER   = 2'd1
  } cfg_idx_e;

  // Per-column increment requests from the classifier to the tally bank.
  typedef struct packed {
    logic gap_a;
    logic gap_b;
    logic aligned;
    logic match;
    logic mismatch;
    logic transition;
    logic transversion;
    logic upper_a;
    logic upper_b;
    logic upper_match;
  } col_flags_t;

endpackage

>>> design/acs_if.sv
interface acs_col_if;
  logic       valid;
  logic       ready;
  logic [7:0] base_a;
  logic [7:0] base_b;
  logic       last_column;

  modport source (output valid, base_a, base_b, last_column, input ready);
  modport sink (input valid, base_a, base_b, last_column, output ready);
endinterface

interface acs_res_if;
  logic                              valid;
  logic                              ready;
  logic [acs_pkg::FIELD_W-1:0] column_count;
  logic [acs_pkg::FIELD_W-1:0] gaps_in_a;
  logic [acs_pkg::FIELD_W-1:0] gaps_in_b;
  logic [acs_pkg::FIELD_W-1:0] aligned_count;
  logic [acs_pkg::FIELD_W-1:0] match_count;
  logic [acs_pkg::FIELD_W-1:0] mismatch_count;
  logic [acs_pkg::FIELD_W-1:0] transition_count;
  logic [acs_pkg::FIELD_W-1:0] transversion_count;
  logic [acs_pkg::FIELD_W-1:0] upper_in_a;
  logic [acs_pkg::FIELD_W-1:0] upper_in_b;
  logic [acs_pkg::FIELD_W-1:0] upper_match_count;
  logic                              keep;

  modport source (output valid, column_count, gaps_in_a, gaps_in_b, aligned_count,
                  match_count, mismatch_count, transition_count, transversion_count,
                  upper_in_a, upper_in_b, upper_match_count, keep, input ready);
  modport sink (input valid, column_count, gaps_in_a, gaps_in_b, aligned_count,
                match_count, mismatch_count, transition_count, transversion_count,
                upper_in_a, upper_in_b, upper_match_count, keep, output ready);
endinterface

interface acs_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [acs_pkg::CFG_IDX_W-1:0] index;
  logic [acs_pkg::FIELD_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> design/alignment_column_statistics_top.sv
// Alignment column statistics.
// Columns arrive on col_i, one transfer per column, carrying the raw ASCII
// characters of both rows and a flag on the final column. Each column is
// registered and classified; an ordinary column is added to eleven saturating
// tallies in the next cycle. On the final column the updated tallies and the
// keep flag are loaded into an output register that drives res_o as soon as
// that register is free; the tallies then restart from zero.
// Throughput is one column per cycle while no final column waits for the
// output register, set by the single column register feeding the tally bank.
// When res_o stalls, ordinary columns keep flowing into the tallies; only a
// final column waits in the column register until the output register frees,
// and col_i.ready drops while it waits.
// cfg_i takes threshold writes (index 0: min_columns, index 1: min_uppercase)
// in every cycle; other indexes are ignored. Reset clears all tallies and
// pipeline valids and loads the thresholds with 900 and 100.
module alignment_column_statistics_top #(
  parameter int unsigned COUNT_BITS = acs_pkg::COUNT_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  acs_col_if.sink   col_i,
  acs_res_if.source res_o,
  acs_cfg_if.sink   cfg_i
);

  localparam int unsigned CMP_W =
    (COUNT_BITS > acs_pkg::FIELD_W) ? COUNT_BITS : acs_pkg::FIELD_W;

  // Threshold registers.
  logic [acs_pkg::FIELD_W-1:0] min_cols_q, min_cols_d;
  logic [acs_pkg::FIELD_W-1:0] min_up_q, min_up_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    min_cols_d = min_cols_q;
    min_up_d = min_up_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        acs_pkg::CFG_MIN_COLUMNS: min_cols_d = cfg_i.data;
        acs_pkg::CFG_MIN_UPPER:   min_up_d = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_cols_q <= acs_pkg::MIN_COLUMNS_RST;
      min_up_q <= acs_pkg::MIN_UPPER_RST;
    end else begin
      min_cols_q <= min_cols_d;
      min_up_q <= min_up_d;
    end
  end

  // Column register.
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_a_q, s1_b_q;
  logic       s1_last_q;
  logic       out_free, s1_go, col_xfer;

  // Output register.
  logic                                                   out_valid_q, out_valid_d;
  logic [acs_pkg::NUM_TALLIES-1:0][acs_pkg::FIELD_W-1:0]  res_q, res_d;
  logic                                                   keep_q, keep_d;
  logic                                                   load_out;

  acs_pkg::col_flags_t                                    flags;
  logic [acs_pkg::NUM_TALLIES-1:0][COUNT_BITS-1:0]        cnt_next;

  assign out_free = !out_valid_q || res_o.ready;
  assign s1_go = s1_valid_q && (!s1_last_q || out_free);
  assign col_i.ready = !s1_valid_q || s1_go;
  assign col_xfer = col_i.valid && col_i.ready;
  assign load_out = s1_go && s1_last_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (col_xfer) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (col_xfer) begin
      s1_a_q <= col_i.base_a;
      s1_b_q <= col_i.base_b;
      s1_last_q <= col_i.last_column;
    end
  end

  acs_classify u_classify (
    .base_a_i (s1_a_q),
    .base_b_i (s1_b_q),
    .flags_o  (flags)
  );

  acs_tally #(
    .COUNT_BITS (COUNT_BITS)
  ) u_tally (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (s1_go),
    .clear_i    (s1_last_q),
    .flags_i    (flags),
    .cnt_next_o (cnt_next)
  );

  always_comb begin
    for (int i = 0; i < acs_pkg::NUM_TALLIES; i++) begin
      res_d[i] = acs_pkg::FIELD_W'(cnt_next[i]);
    end
    keep_d = (CMP_W'(cnt_next[acs_pkg::T_COLS]) >= CMP_W'(min_cols_q)) &&
             (CMP_W'(cnt_next[acs_pkg::T_UPA]) >= CMP_W'(min_up_q)) &&
             (CMP_W'(cnt_next[acs_pkg::T_UPB]) >= CMP_W'(min_up_q)) &&
             (CMP_W'(cnt_next[acs_pkg::T_UPMATCH]) >= CMP_W'(min_up_q));
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      res_q <= res_d;
      keep_q <= keep_d;
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.column_count = res_q[acs_pkg::T_COLS];
  assign res_o.gaps_in_a = res_q[acs_pkg::T_GAPA];
  assign res_o.gaps_in_b = res_q[acs_pkg::T_GAPB];
  assign res_o.aligned_count = res_q[acs_pkg::T_ALIGNED];
  assign res_o.match_count = res_q[acs_pkg::T_MATCH];
  assign res_o.mismatch_count = res_q[acs_pkg::T_MISMATCH];
  assign res_o.transition_count = res_q[acs_pkg::T_TRANSITION];
  assign res_o.transversion_count = res_q[acs_pkg::T_TRANSVERSION];
  assign res_o.upper_in_a = res_q[acs_pkg::T_UPA];
  assign res_o.upper_in_b = res_q[acs_pkg::T_UPB];
  assign res_o.upper_match_count = res_q[acs_pkg::T_UPMATCH];
  assign res_o.keep = keep_q;

`ifndef SYNTHESIS
  // A final column that leaves the column register always produces a result.
  a_last_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_valid_q)
    else $error("final column did not load the output register");

  // The input side only stalls behind a final column blocked by a full output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !col_i.ready |-> (s1_valid_q && s1_last_q && out_valid_q && !res_o.ready))
    else $error("column input stalled without a blocked final column");

  // Every mismatch is split into exactly one substitution class.
  a_class_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (flags.mismatch == (flags.transition || flags.transversion)) &&
                   !(flags.transition && flags.transversion))
    else $error("mismatch classification inconsistent");
`endif

endmodule

>>> design/acs_classify.sv
module acs_classify (
  input  logic [7:0]          base_a_i,
  input  logic [7:0]          base_b_i,
  output acs_pkg::col_flags_t flags_o
);

  function automatic logic [7:0] fold(input logic [7:0] c);
    if (c >= acs_pkg::CH_LC_FIRST && c <= acs_pkg::CH_LC_LAST) begin
      return c - acs_pkg::CASE_OFFSET;
    end
    return c;
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= acs_pkg::CH_UC_FIRST) && (c <= acs_pkg::CH_UC_LAST);
  endfunction

  logic [7:0] fa, fb;
  logic       gap_a, gap_b, aligned, same_fold;
  logic       a_purine, b_purine, b_pyrimidine, same_class;

  always_comb begin
    fa = fold(base_a_i);
    fb = fold(base_b_i);
    gap_a = (base_a_i == acs_pkg::CH_GAP);
    gap_b = (base_b_i == acs_pkg::CH_GAP);
    aligned = !gap_a && !gap_b;
    same_fold = (fa == fb);
    a_purine = (fa == acs_pkg::CH_A) || (fa == acs_pkg::CH_G);
    b_purine = (fb == acs_pkg::CH_A) || (fb == acs_pkg::CH_G);
    b_pyrimidine = (fb == acs_pkg::CH_C) || (fb == acs_pkg::CH_T);
    // Anything that is not a purine in the first row goes down the pyrimidine test.
    same_class = a_purine ? b_purine : b_pyrimidine;

    flags_o.gap_a = gap_a;
    flags_o.gap_b = gap_b;
    flags_o.aligned = aligned;
    flags_o.match = !gap_a && same_fold;
    flags_o.mismatch = aligned && !same_fold;
    flags_o.transition = aligned && !same_fold && same_class;
    flags_o.transversion = aligned && !same_fold && !same_class;
    flags_o.upper_a = !gap_a && is_upper(base_a_i) && (base_a_i != acs_pkg::CH_N);
    flags_o.upper_b = !gap_b && is_upper(base_b_i) && (base_b_i != acs_pkg::CH_N);
    flags_o.upper_match = aligned && same_fold && is_upper(base_a_i) && is_upper(base_b_i);
  end

endmodule

>>> design/acs_tally.sv
module acs_tally #(
  parameter int unsigned COUNT_BITS = acs_pkg::COUNT_BITS_DEF
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               step_i,
  input  logic                                               clear_i,
  input  acs_pkg::col_flags_t                                flags_i,
  output logic [acs_pkg::NUM_TALLIES-1:0][COUNT_BITS-1:0]    cnt_next_o
);

  logic [acs_pkg::NUM_TALLIES-1:0][COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [acs_pkg::NUM_TALLIES-1:0]                 bump;

  always_comb begin
    bump = '0;
    bump[acs_pkg::T_COLS] = 1'b1;
    bump[acs_pkg::T_GAPA] = flags_i.gap_a;
    bump[acs_pkg::T_GAPB] = flags_i.gap_b;
    bump[acs_pkg::T_ALIGNED] = flags_i.aligned;
    bump[acs_pkg::T_MATCH] = flags_i.match;
    bump[acs_pkg::T_MISMATCH] = flags_i.mismatch;
    bump[acs_pkg::T_TRANSITION] = flags_i.transition;
    bump[acs_pkg::T_TRANSVERSION] = flags_i.transversion;
    bump[acs_pkg::T_UPA] = flags_i.upper_a;
    bump[acs_pkg::T_UPB] = flags_i.upper_b;
    bump[acs_pkg::T_UPMATCH] = flags_i.upper_match;
  end

  // Saturating increments; the counters stick at all ones.
  always_comb begin
    for (int i = 0; i < acs_pkg::NUM_TALLIES; i++) begin
      if (bump[i] && !(&cnt_q[i])) begin
        cnt_next_o[i] = cnt_q[i] + COUNT_BITS'(1);
      end else begin
        cnt_next_o[i] = cnt_q[i];
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (step_i) begin
      cnt_d = clear_i ? '0 : cnt_next_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> tb/sv/tb_alignment_column_statistics_top.sv
module tb_alignment_column_statistics_top;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned PRESSURE_HOLD = 300;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam logic [acs_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  // One result: the eleven tallies in slot order, then the keep flag.
  typedef logic [acs_pkg::NUM_TALLIES:0][acs_pkg::FIELD_W-1:0] stats_t;

  class alignment_stats_book;
    logic [acs_pkg::FIELD_W-1:0] tally [acs_pkg::NUM_TALLIES];
    logic [acs_pkg::FIELD_W-1:0] min_columns;
    logic [acs_pkg::FIELD_W-1:0] min_upper;
    stats_t expected_stats [$];
    int unsigned failures;
    int unsigned results_checked;
    int unsigned columns_seen;
    int unsigned kept;

    function new();
      foreach (tally[i]) tally[i] = '0;
      min_columns = acs_pkg::MIN_COLUMNS_RST;
      min_upper = acs_pkg::MIN_UPPER_RST;
      failures = 0;
      results_checked = 0;
      columns_seen = 0;
      kept = 0;
    endfunction

    function int unsigned pending();
      return expected_stats.size();
    endfunction

    function void set_threshold(logic [acs_pkg::CFG_IDX_W-1:0] idx,
                                logic [acs_pkg::FIELD_W-1:0] val);
      case (idx)
        acs_pkg::CFG_MIN_COLUMNS: min_columns = val;
        acs_pkg::CFG_MIN_UPPER:   min_upper = val;
        default: ;
      endcase
    endfunction

    function logic [7:0] fold_case(logic [7:0] c);
      if (c >= acs_pkg::CH_LC_FIRST && c <= acs_pkg::CH_LC_LAST)
        return c - acs_pkg::CASE_OFFSET;
      return c;
    endfunction

    function bit is_upper(logic [7:0] c);
      return c >= acs_pkg::CH_UC_FIRST && c <= acs_pkg::CH_UC_LAST;
    endfunction

    function void bump(int unsigned slot);
      if (tally[slot] != '1) tally[slot] = tally[slot] + 1'b1;
    endfunction

    function void note_column(logic [7:0] ra, logic [7:0] rb, bit last);
      logic [7:0] fa;
      logic [7:0] fb;
      bit gap_a;
      bit gap_b;
      bit same_class;
      stats_t want;
      fa = fold_case(ra);
      fb = fold_case(rb);
      gap_a = (ra == acs_pkg::CH_GAP);
      gap_b = (rb == acs_pkg::CH_GAP);
      columns_seen++;
      bump(acs_pkg::T_COLS);
      if (gap_a) bump(acs_pkg::T_GAPA);
      if (gap_b) bump(acs_pkg::T_GAPB);
      if (!gap_a && fa == fb) bump(acs_pkg::T_MATCH);
      if (!gap_a && is_upper(ra) && ra != acs_pkg::CH_N) bump(acs_pkg::T_UPA);
      if (!gap_b && is_upper(rb) && rb != acs_pkg::CH_N) bump(acs_pkg::T_UPB);
      if (!gap_a && !gap_b) begin
        bump(acs_pkg::T_ALIGNED);
        if (fa != fb) begin
          bump(acs_pkg::T_MISMATCH);
          // Only a purine first base is judged against purines; anything else
          // goes down the pyrimidine branch.
          if (fa == acs_pkg::CH_A || fa == acs_pkg::CH_G)
            same_class = (fb == acs_pkg::CH_A || fb == acs_pkg::CH_G);
          else
            same_class = (fb == acs_pkg::CH_C || fb == acs_pkg::CH_T);
          bump(same_class ? acs_pkg::T_TRANSITION : acs_pkg::T_TRANSVERSION);
        end else if (is_upper(ra) && is_upper(rb)) begin
          bump(acs_pkg::T_UPMATCH);
        end
      end
      if (last) begin
        for (int unsigned i = 0; i < acs_pkg::NUM_TALLIES; i++) want[i] = tally[i];
        want[acs_pkg::NUM_TALLIES] = acs_pkg::FIELD_W'(
          tally[acs_pkg::T_COLS] >= min_columns &&
          tally[acs_pkg::T_UPA] >= min_upper &&
          tally[acs_pkg::T_UPB] >= min_upper &&
          tally[acs_pkg::T_UPMATCH] >= min_upper);
        if (want[acs_pkg::NUM_TALLIES] != '0) kept++;
        expected_stats = {expected_stats, want};
        foreach (tally[i]) tally[i] = '0;
      end
    endfunction

    function string field_label(int unsigned i);
      case (i)
        acs_pkg::T_COLS:         return "column_count";
        acs_pkg::T_GAPA:         return "gaps_in_a";
        acs_pkg::T_GAPB:         return "gaps_in_b";
        acs_pkg::T_ALIGNED:      return "aligned_count";
        acs_pkg::T_MATCH:        return "match_count";
        acs_pkg::T_MISMATCH:     return "mismatch_count";
        acs_pkg::T_TRANSITION:   return "transition_count";
        acs_pkg::T_TRANSVERSION: return "transversion_count";
        acs_pkg::T_UPA:          return "upper_in_a";
        acs_pkg::T_UPB:          return "upper_in_b";
        acs_pkg::T_UPMATCH:      return "upper_match_count";
        default:                 return "keep";
      endcase
    endfunction

    function void check_stats(stats_t got);
      stats_t want;
      if (expected_stats.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("unexpected result with column_count %0d, none pending",
                   got[acs_pkg::T_COLS]);
        return;
      end
      want = expected_stats.pop_front();
      results_checked++;
      for (int unsigned i = 0; i <= acs_pkg::NUM_TALLIES; i++) begin
        if (got[i] !== want[i]) begin
          failures++;
          if (failures <= REPORT_LIMIT)
            $display("result %0d %s: expected %0d, got %0d",
                     results_checked, field_label(i), want[i], got[i]);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  acs_col_if col_if ();
  acs_res_if res_if ();
  acs_cfg_if cfg_if ();

  alignment_column_statistics_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .col_i  (col_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  alignment_stats_book book = new();

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_stamp = 0;
  int unsigned settings_used = 1;

  always #4 clk_i = ~clk_i;

  // Receiver: checks every result transfer and decides ready for the next edge.
  initial begin
    stats_t got;
    int unsigned hold_left;
    int unsigned hold_taken;
    hold_left = 0;
    hold_taken = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        got[acs_pkg::T_COLS] = res_if.column_count;
        got[acs_pkg::T_GAPA] = res_if.gaps_in_a;
        got[acs_pkg::T_GAPB] = res_if.gaps_in_b;
        got[acs_pkg::T_ALIGNED] = res_if.aligned_count;
        got[acs_pkg::T_MATCH] = res_if.match_count;
        got[acs_pkg::T_MISMATCH] = res_if.mismatch_count;
        got[acs_pkg::T_TRANSITION] = res_if.transition_count;
        got[acs_pkg::T_TRANSVERSION] = res_if.transversion_count;
        got[acs_pkg::T_UPA] = res_if.upper_in_a;
        got[acs_pkg::T_UPB] = res_if.upper_in_b;
        got[acs_pkg::T_UPMATCH] = res_if.upper_match_count;
        got[acs_pkg::NUM_TALLIES] = acs_pkg::FIELD_W'(res_if.keep);
        book.check_stats(got);
      end
      if (hold_taken != hold_stamp) begin
        hold_taken = hold_stamp;
        hold_left = PRESSURE_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Watchdog: ends the run when no transfer of any kind happens for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((col_if.valid && col_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer in %0d cycles, %0d results pending",
                 quiet, book.pending());
        $display("FAIL");
        $finish;
      end
    end
  end

  // Leaves valid high after the transfer so that back-to-back columns never
  // lower and raise it within one step.
  task automatic send_column(logic [7:0] a, logic [7:0] b, bit last);
    while ($urandom_range(99) < idle_pct) begin
      col_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    col_if.valid <= 1'b1;
    col_if.base_a <= a;
    col_if.base_b <= b;
    col_if.last_column <= last;
    do @(posedge clk_i); while (!col_if.ready);
    book.note_column(a, b, last);
  endtask

  task automatic write_reg(logic [acs_pkg::CFG_IDX_W-1:0] idx,
                           logic [acs_pkg::FIELD_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    book.set_threshold(idx, val);
  endtask

  task automatic set_thresholds(logic [acs_pkg::FIELD_W-1:0] cols,
                                logic [acs_pkg::FIELD_W-1:0] upper);
    write_reg(acs_pkg::CFG_MIN_COLUMNS, cols);
    write_reg(acs_pkg::CFG_MIN_UPPER, upper);
    cfg_if.valid <= 1'b0;
    settings_used++;
  endtask

  // Waits for every pending result and for any column still in the pipeline.
  task automatic settle();
    col_if.valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [7:0] random_base(bit mostly_upper);
    logic [7:0] acgt [4];
    int unsigned r;
    acgt = '{acs_pkg::CH_A, acs_pkg::CH_C, acs_pkg::CH_G, acs_pkg::CH_T};
    r = $urandom_range(99);
    if (mostly_upper && r < 90) return acgt[$urandom_range(3)];
    if (r < 40) return acgt[$urandom_range(3)];
    if (r < 55) return acgt[$urandom_range(3)] | acs_pkg::CASE_OFFSET;
    if (r < 62)
      return $urandom_range(1) ? acs_pkg::CH_N : (acs_pkg::CH_N | acs_pkg::CASE_OFFSET);
    if (r < 74) return acs_pkg::CH_GAP;
    return 8'($urandom_range(255));
  endfunction

  task automatic send_alignment(int unsigned len, bit mostly_upper);
    logic [7:0] a;
    logic [7:0] b;
    int unsigned r;
    for (int unsigned i = 0; i < len; i++) begin
      a = random_base(mostly_upper);
      r = $urandom_range(99);
      if (r < 45) b = a;
      else if (r < 55) b = a ^ acs_pkg::CASE_OFFSET;
      else b = random_base(mostly_upper);
      send_column(a, b, i == len - 1);
    end
  endtask

  task automatic run_phase(int unsigned columns);
    int unsigned sent;
    int unsigned len;
    int unsigned r;
    sent = 0;
    while (sent < columns) begin
      r = $urandom_range(99);
      if (r < 70) len = $urandom_range(8, 1);
      else if (r < 95) len = $urandom_range(40, 9);
      else len = $urandom_range(120, 41);
      send_alignment(len, $urandom_range(4) == 0);
      sent += len;
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    col_if.valid <= 1'b0;
    col_if.base_a <= '0;
    col_if.base_b <= '0;
    col_if.last_column <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= acs_pkg::CFG_MIN_COLUMNS;
    cfg_if.data <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed columns under the reset thresholds.
    send_column("A", "A", 1'b0);
    send_column("a", "A", 1'b0);
    send_column("G", "a", 1'b0);
    send_column("C", "t", 1'b0);
    send_column("A", "C", 1'b0);
    send_column("T", "g", 1'b0);
    send_column("N", "N", 1'b0);
    send_column("n", "N", 1'b0);
    send_column("N", "C", 1'b0);
    send_column("x", "t", 1'b0);
    send_column("-", "A", 1'b0);
    send_column("A", "-", 1'b0);
    send_column("-", "-", 1'b0);
    send_column(8'h00, 8'hFF, 1'b0);
    send_column(8'hFF, 8'hFF, 1'b0);
    send_column(8'hE1, 8'hC1, 1'b0);
    send_column("z", "Z", 1'b0);
    send_column(8'h60, "@", 1'b0);
    send_column("{", "[", 1'b0);
    send_column("g", "G", 1'b1);
    send_column("Z", "-", 1'b1);
    send_column("-", "-", 1'b1);
    send_column("A", "G", 1'b1);
    // A long uppercase-heavy alignment that can clear the reset thresholds.
    send_alignment($urandom_range(960, 900), 1'b1);
    settle();

    // No idling; thresholds at zero, then a long hold on the result side.
    write_reg(CFG_UNUSED_IDX, '1);
    set_thresholds('0, '0);
    run_phase(120);
    hold_stamp++;
    for (int unsigned i = 0; i < 40; i++) send_alignment($urandom_range(2, 1), 1'b0);
    run_phase(60);
    settle();

    set_thresholds(acs_pkg::FIELD_W'($urandom_range(12, 1)),
                   acs_pkg::FIELD_W'($urandom_range(4)));
    idle_pct = 49;
    run_phase(150);
    settle();

    set_thresholds('1, '1);
    idle_pct = 0;
    stall_pct = 49;
    run_phase(150);
    settle();

    set_thresholds(acs_pkg::FIELD_W'($urandom_range(30, 2)),
                   acs_pkg::FIELD_W'($urandom_range(10, 1)));
    idle_pct = 12;
    stall_pct = 12;
    run_phase(150);
    settle();

    $display("Streamed %0d columns into %0d alignments under %0d threshold settings.",
             book.columns_seen, book.results_checked, settings_used);
    $display("%0d alignments were kept; %0d field mismatches found.",
             book.kept, book.failures);
    if (book.failures == 0 && book.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
